### hdl/rsq_pkg.sv
// ----------------------------------------------------------------------------
// rsq_pkg
// Shared types, constants and constant functions of the rotary sin/cos
// quantizer.
// ----------------------------------------------------------------------------
package rsq_pkg;

    localparam int FRAC_BITS    = 18;
    localparam int CORDIC_STEPS = 18;
    // Cycles from the accepting edge of a request to the edge that takes its result.
    localparam int LATENCY      = 45;

    localparam logic [29:0] TURN_PER_RAD = 30'd683565276;
    localparam logic [33:0] CORDIC_GAIN  = 34'sd652032874;

    localparam logic [31:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215};

    localparam logic [2:0] CFG_FREQ_STEP = 3'd0;
    localparam logic [2:0] CFG_SIN_GAIN  = 3'd1;
    localparam logic [2:0] CFG_SIN_ZERO  = 3'd2;
    localparam logic [2:0] CFG_COS_GAIN  = 3'd3;
    localparam logic [2:0] CFG_COS_ZERO  = 3'd4;

    typedef struct packed {
        logic [15:0] position;
        logic [6:0]  pair_index;
    } t_request;

    typedef struct packed {
        logic [15:0] sin_code;
        logic [15:0] cos_code;
    } t_result;

    // Side information that rides along the exponent pipeline.
    typedef struct packed {
        logic [15:0] position;
        logic [12:0] int_exp;
    } t_exp_side;

    // Floor square root of a 64-bit value, bit by bit.
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] bitv;
        v    = v_in;
        r    = '0;
        bitv = 64'h1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + bitv) begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    // Coefficient 2^(-2^-idx) in Q0.32, by repeated square roots from 0.5.
    function automatic logic [31:0] exp_coef(input int idx);
        logic [63:0] c;
        c = 64'h8000_0000;
        for (int j = 1; j <= FRAC_BITS; j++) begin
            if (j <= idx) begin
                c = isqrt64(c << 32);
            end
        end
        return c[31:0];
    endfunction

endpackage

### hdl/rsq_exp2.sv
// ----------------------------------------------------------------------------
// rsq_exp2
// Eighteen-stage pipeline that forms 2^-f in Q.32 for an 18-bit fraction f,
// one conditional constant multiply per stage.
// ----------------------------------------------------------------------------
module rsq_exp2
    import rsq_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [17:0]     i_frac,
    input  t_exp_side       i_side,
    output logic            o_valid,
    output logic [32:0]     o_mant,
    output t_exp_side       o_side
);

    logic            r_v    [0:FRAC_BITS];
    logic [32:0]     r_m    [0:FRAC_BITS];
    logic [17:0]     r_f    [0:FRAC_BITS];
    t_exp_side       r_side [0:FRAC_BITS];

    always_comb begin
        r_v[0]    = i_valid;
        r_m[0]    = 33'h1_0000_0000;
        r_f[0]    = i_frac;
        r_side[0] = i_side;
    end

    for (genvar g = 1; g <= FRAC_BITS; g++) begin : g_stage
        localparam logic [31:0] COEF = exp_coef(g);
        logic [64:0] n_prod;
        logic [32:0] n_m;

        always_comb begin
            n_prod = r_m[g-1] * {33'd0, COEF};
            n_m    = r_f[g-1][FRAC_BITS-g] ? n_prod[64:32] : r_m[g-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else begin
                r_v[g] <= r_v[g-1];
            end
            r_m[g]    <= n_m;
            r_f[g]    <= r_f[g-1];
            r_side[g] <= r_side[g-1];
        end
    end

    assign o_valid = r_v[FRAC_BITS];
    assign o_mant  = r_m[FRAC_BITS];
    assign o_side  = r_side[FRAC_BITS];

endmodule

### hdl/rsq_cordic.sv
// ----------------------------------------------------------------------------
// rsq_cordic
// Eighteen-stage rotation-mode CORDIC on Q3.30 values with the angle in turns.
// ----------------------------------------------------------------------------
module rsq_cordic
    import rsq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [33:0] i_angle,
    input  logic [1:0]         i_quad,
    output logic               o_valid,
    output logic signed [33:0] o_x,
    output logic signed [33:0] o_y,
    output logic [1:0]         o_quad
);

    logic               r_v [0:CORDIC_STEPS];
    logic signed [33:0] r_x [0:CORDIC_STEPS];
    logic signed [33:0] r_y [0:CORDIC_STEPS];
    logic signed [33:0] r_z [0:CORDIC_STEPS];
    logic [1:0]         r_q [0:CORDIC_STEPS];

    always_comb begin
        r_v[0] = i_valid;
        r_x[0] = CORDIC_GAIN;
        r_y[0] = '0;
        r_z[0] = i_angle;
        r_q[0] = i_quad;
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_stage
        logic signed [33:0] n_dx;
        logic signed [33:0] n_dy;
        logic signed [33:0] n_at;

        always_comb begin
            n_dx = r_y[g] >>> g;
            n_dy = r_x[g] >>> g;
            n_at = signed'({2'b00, ATAN_TURNS[g]});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else begin
                r_v[g+1] <= r_v[g];
            end
            if (!r_z[g][33]) begin
                r_x[g+1] <= r_x[g] - n_dx;
                r_y[g+1] <= r_y[g] + n_dy;
                r_z[g+1] <= r_z[g] - n_at;
            end else begin
                r_x[g+1] <= r_x[g] + n_dx;
                r_y[g+1] <= r_y[g] - n_dy;
                r_z[g+1] <= r_z[g] + n_at;
            end
            r_q[g+1] <= r_q[g];
        end
    end

    assign o_valid = r_v[CORDIC_STEPS];
    assign o_x     = r_x[CORDIC_STEPS];
    assign o_y     = r_y[CORDIC_STEPS];
    assign o_quad  = r_q[CORDIC_STEPS];

endmodule

### hdl/rotary_sin_cos_quantizer.sv
// ----------------------------------------------------------------------------
// rotary_sin_cos_quantizer
// Computes one quantized rotary-embedding sine/cosine pair per request.
// ----------------------------------------------------------------------------
// A request (position, pair index) is taken on every edge where start is high;
// busy never rises, so one request can be issued in every clock cycle. The
// matching result is on the result ports for one cycle, flagged by o_valid, in
// request order, after it has passed through the pipeline: 18 stages of the
// inverse-frequency exponent, 18 CORDIC stages and nine stages of
// multiplies, shifts and quantization around them. The result cannot be held
// off, so the receiver must take it in that cycle. The configuration registers
// are written through their own channel, which is always ready; they should be
// changed only while no request is in flight.
// ----------------------------------------------------------------------------
module rotary_sin_cos_quantizer
    import rsq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_request    i_req,
    output logic        o_valid,
    output t_result     o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [23:0]        r_freq_step;
    logic [23:0]        r_sin_gain;
    logic signed [16:0] r_sin_zero;
    logic [23:0]        r_cos_gain;
    logic signed [16:0] r_cos_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_step <= 24'd81630;
            r_sin_gain  <= 24'd8388608;
            r_sin_zero  <= 17'sd32768;
            r_cos_gain  <= 24'd8388608;
            r_cos_zero  <= 17'sd32768;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FREQ_STEP: r_freq_step <= i_cfg_data;
                CFG_SIN_GAIN:  r_sin_gain  <= i_cfg_data;
                CFG_SIN_ZERO:  r_sin_zero  <= signed'(i_cfg_data[16:0]);
                CFG_COS_GAIN:  r_cos_gain  <= i_cfg_data;
                CFG_COS_ZERO:  r_cos_zero  <= signed'(i_cfg_data[16:0]);
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: capture the request.
    // ------------------------------------------------------------------
    logic        r1_v;
    t_request    r1_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= start;
        end
        r1_req <= i_req;
    end

    // ------------------------------------------------------------------
    // Stage 2: exponent k*freq_step in Q13.18, split into integer and fraction.
    // ------------------------------------------------------------------
    logic        r2_v;
    logic [17:0] r2_frac;
    t_exp_side   r2_side;
    logic [30:0] n_exp;

    assign n_exp = r1_req.pair_index * r_freq_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_frac          <= n_exp[17:0];
        r2_side.int_exp  <= n_exp[30:18];
        r2_side.position <= r1_req.position;
    end

    // Fractional power of two, one fraction bit per stage.
    logic        ex_v;
    logic [32:0] ex_mant;
    t_exp_side   ex_side;

    rsq_exp2 u_exp2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_v),
        .i_frac  (r2_frac),
        .i_side  (r2_side),
        .o_valid (ex_v),
        .o_mant  (ex_mant),
        .o_side  (ex_side)
    );

    // ------------------------------------------------------------------
    // Stage 3: inverse frequency, the mantissa shifted by the integer part.
    // Exponents beyond 63 give zero.
    // ------------------------------------------------------------------
    logic        r3_v;
    logic [32:0] r3_inv;
    logic [15:0] r3_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= ex_v;
        end
        r3_inv <= (ex_side.int_exp > 13'd63) ? 33'd0 : (ex_mant >> ex_side.int_exp[5:0]);
        r3_pos <= ex_side.position;
    end

    // Stage 4: position times inverse frequency, radians in Q.32.
    logic        r4_v;
    logic [48:0] r4_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
        r4_rad <= r3_pos * r3_inv;
    end

    // Stage 5: split product of radians by turns per radian.
    logic        r5_v;
    logic [31:0] r5_hi;
    logic [29:0] r5_lo;
    logic [46:0] n_hi_prod;
    logic [61:0] n_lo_prod;

    assign n_hi_prod = r4_rad[48:32] * TURN_PER_RAD;
    assign n_lo_prod = r4_rad[31:0] * TURN_PER_RAD;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r4_v;
        end
        r5_hi <= n_hi_prod[31:0];
        r5_lo <= n_lo_prod[61:32];
    end

    // ------------------------------------------------------------------
    // Stage 6: angle in turns, folded into a quadrant and a residual in
    // [-1/8, 1/8) turn.
    // ------------------------------------------------------------------
    logic               r6_v;
    logic [1:0]         r6_quad;
    logic signed [33:0] r6_res;
    logic [31:0]        n_ang;
    logic [31:0]        n_fold;

    assign n_ang  = r5_hi + {2'b00, r5_lo};
    assign n_fold = n_ang + 32'h2000_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else begin
            r6_v <= r5_v;
        end
        r6_quad <= n_fold[31:30];
        r6_res  <= signed'({4'b0000, n_fold[29:0]}) - 34'sh2000_0000;
    end

    logic               cd_v;
    logic signed [33:0] cd_x;
    logic signed [33:0] cd_y;
    logic [1:0]         cd_quad;

    rsq_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r6_v),
        .i_angle (r6_res),
        .i_quad  (r6_quad),
        .o_valid (cd_v),
        .o_x     (cd_x),
        .o_y     (cd_y),
        .o_quad  (cd_quad)
    );

    // ------------------------------------------------------------------
    // Stage 7: round to Q1.16, clamp, and map the quadrant.
    // ------------------------------------------------------------------
    logic               r7_v;
    logic signed [17:0] r7_sin;
    logic signed [17:0] r7_cos;
    logic signed [33:0] n_ys;
    logic signed [33:0] n_xs;
    logic signed [17:0] n_s;
    logic signed [17:0] n_c;

    always_comb begin
        n_ys = (cd_y + 34'sd8192) >>> 14;
        n_xs = (cd_x + 34'sd8192) >>> 14;
        if (n_ys > 34'sd65536) begin
            n_s = 18'sd65536;
        end else if (n_ys < -34'sd65536) begin
            n_s = -18'sd65536;
        end else begin
            n_s = n_ys[17:0];
        end
        if (n_xs > 34'sd65536) begin
            n_c = 18'sd65536;
        end else if (n_xs < -34'sd65536) begin
            n_c = -18'sd65536;
        end else begin
            n_c = n_xs[17:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else begin
            r7_v <= cd_v;
        end
        case (cd_quad)
            2'd0: begin
                r7_sin <= n_s;
                r7_cos <= n_c;
            end
            2'd1: begin
                r7_sin <= n_c;
                r7_cos <= -n_s;
            end
            2'd2: begin
                r7_sin <= -n_s;
                r7_cos <= -n_c;
            end
            default: begin
                r7_sin <= -n_c;
                r7_cos <= n_s;
            end
        endcase
    end

    // Stage 8: magnitude times gain, sign kept aside.
    logic        r8_v;
    logic [40:0] r8_sin_prod;
    logic [40:0] r8_cos_prod;
    logic        r8_sin_neg;
    logic        r8_cos_neg;
    logic [16:0] n_sin_mag;
    logic [16:0] n_cos_mag;
    logic [17:0] n_sin_abs;
    logic [17:0] n_cos_abs;

    always_comb begin
        n_sin_abs = r7_sin[17] ? 18'(-r7_sin) : 18'(r7_sin);
        n_cos_abs = r7_cos[17] ? 18'(-r7_cos) : 18'(r7_cos);
        n_sin_mag = n_sin_abs[16:0];
        n_cos_mag = n_cos_abs[16:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else begin
            r8_v <= r7_v;
        end
        r8_sin_prod <= n_sin_mag * r_sin_gain;
        r8_cos_prod <= n_cos_mag * r_cos_gain;
        r8_sin_neg  <= r7_sin[17];
        r8_cos_neg  <= r7_cos[17];
    end

    // ------------------------------------------------------------------
    // Stage 9: round half away from zero, add the zero point, saturate.
    // ------------------------------------------------------------------
    logic        r_valid;
    t_result     r_result;
    logic [41:0] n_sin_rnd;
    logic [41:0] n_cos_rnd;
    logic signed [19:0] n_sin_q;
    logic signed [19:0] n_cos_q;
    logic [15:0] n_sin_code;
    logic [15:0] n_cos_code;

    always_comb begin
        n_sin_rnd = ({1'b0, r8_sin_prod} + 42'h80_0000) >> 24;
        n_cos_rnd = ({1'b0, r8_cos_prod} + 42'h80_0000) >> 24;
        n_sin_q   = signed'({2'b00, n_sin_rnd[17:0]});
        n_cos_q   = signed'({2'b00, n_cos_rnd[17:0]});
        if (r8_sin_neg) begin
            n_sin_q = -n_sin_q;
        end
        if (r8_cos_neg) begin
            n_cos_q = -n_cos_q;
        end
        n_sin_q = n_sin_q + 20'(r_sin_zero);
        n_cos_q = n_cos_q + 20'(r_cos_zero);
        if (n_sin_q < 20'sd0) begin
            n_sin_code = 16'd0;
        end else if (n_sin_q > 20'sd65535) begin
            n_sin_code = 16'hFFFF;
        end else begin
            n_sin_code = n_sin_q[15:0];
        end
        if (n_cos_q < 20'sd0) begin
            n_cos_code = 16'd0;
        end else if (n_cos_q > 20'sd65535) begin
            n_cos_code = 16'hFFFF;
        end else begin
            n_cos_code = n_cos_q[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r8_v;
        end
        r_result.sin_code <= n_sin_code;
        r_result.cos_code <= n_cos_code;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

### hdl/rsq_checker.sv
// ----------------------------------------------------------------------------
// rsq_checker
// Port-level checks of the rotary sin/cos quantizer, bound to the top level.
// ----------------------------------------------------------------------------
module rsq_checker
    import rsq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready
);

    // Every result strobe traces back to a request accepted a fixed latency earlier.
    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching request");

    // The pipeline never pushes back on requests.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    // Configuration writes are always taken.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write stalled");

    // No result strobe is out at the first clock edge that sees reset released.
    a_quiet_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_valid)
        else $error("result strobe right after reset");

endmodule

bind rotary_sin_cos_quantizer rsq_checker u_rsq_checker (.*);
